// ===== hw/rtl/metric_trace_ring_buffer_top_macros.svh =====
// Assertion macros shared by the trace ring buffer RTL.
// Each macro expects signals named clk and arst_n in the using module.
`ifndef METRIC_TRACE_RING_BUFFER_TOP_MACROS_SVH
`define METRIC_TRACE_RING_BUFFER_TOP_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define MTRB_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define MTRB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

// Consequent must hold later than the antecedent, not in the same cycle.
`define MTRB_ASSERT_AFTER2(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> ##2 (cons)) \
		else $error("assertion failed");

`endif

// ===== hw/rtl/mtrb_pkg.sv =====
// Shared types and constants of the metric trace ring buffer.
// No dependencies; the top, front end, command queue and back end refer to it by scoped names.
package mtrb_pkg;

	localparam int RING_ENTRIES = 1024;
	localparam int SLOT_W = (RING_ENTRIES > 1) ? $clog2(RING_ENTRIES) : 1;

	typedef enum logic [1:0] {
		ST_WRITTEN    = 2'd0,
		ST_OVERFLOW   = 2'd1,
		ST_READ_OK    = 2'd2,
		ST_READ_EMPTY = 2'd3
	} status_t;

	typedef enum logic {
		OP_WRITE = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef struct packed {
		logic [7:0]         kind;
		logic [31:0]        process;
		logic signed [31:0] device;
		logic [63:0]        tstamp;
		logic [63:0]        value;
		logic [63:0]        addr;
	} rec_t;

	localparam int REC_W = $bits(rec_t);

	// Classified command handed from the front end to the back end.
	typedef struct packed {
		logic              is_write;
		status_t           status;
		logic [SLOT_W-1:0] slot;
		logic [31:0]       ovf_total;
		rec_t              rec;
	} cmd_t;

endpackage

// ===== hw/rtl/metric_trace_ring_buffer_top.sv =====
// Results strobe done after the command queue and the back-end result registers.
// Throughput: one item per cycle; busy only rises if the command queue fills,
// which the back end prevents by draining one command every cycle (single RAM port).
// Reset clears both ring positions, the slot counters and the overflow count;
// record RAM contents are not cleared. The receiver cannot stall results.
// Depends on mtrb_pkg, mtrb_front, mtrb_cmd_queue, mtrb_back and the macros header.
`include "metric_trace_ring_buffer_top_macros.svh"

module metric_trace_ring_buffer_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               op,
	input  logic [7:0]         metric_kind,
	input  logic [31:0]        process_id,
	input  logic signed [31:0] device_index,
	input  logic [63:0]        time_ns,
	input  logic [63:0]        metric_value,
	input  logic [63:0]        address_tag,
	output logic               done,
	output logic [1:0]         status,
	output logic [7:0]         rd_kind,
	output logic [31:0]        rd_process,
	output logic signed [31:0] rd_device,
	output logic [63:0]        rd_time,
	output logic [63:0]        rd_value,
	output logic [63:0]        rd_address,
	output logic [31:0]        overflow_total
);

	logic           q_full;
	logic           push;
	mtrb_pkg::cmd_t push_cmd;
	logic           head_valid;
	mtrb_pkg::cmd_t head_cmd;
	logic           pop;

	assign busy = q_full;

	mtrb_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.full        (q_full),
		.op          (op),
		.metric_kind (metric_kind),
		.process_id  (process_id),
		.device_index(device_index),
		.time_ns     (time_ns),
		.metric_value(metric_value),
		.address_tag (address_tag),
		.push        (push),
		.cmd         (push_cmd)
	);

	mtrb_cmd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_cmd  (push_cmd),
		.pop       (pop),
		.full      (q_full),
		.head_valid(head_valid),
		.head_cmd  (head_cmd)
	);

	mtrb_back u_back (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd_valid     (head_valid),
		.cmd           (head_cmd),
		.cmd_pop       (pop),
		.done          (done),
		.status        (status),
		.rd_kind       (rd_kind),
		.rd_process    (rd_process),
		.rd_device     (rd_device),
		.rd_time       (rd_time),
		.rd_value      (rd_value),
		.rd_address    (rd_address),
		.overflow_total(overflow_total)
	);

	`MTRB_ASSERT_AFTER2(a_accept_to_done, start && !busy, done)
	`MTRB_ASSERT_NOW(a_empty_read_zero, done && (status == mtrb_pkg::ST_READ_EMPTY), (rd_kind == 8'd0) && (rd_time == 64'd0))

endmodule

// ===== hw/rtl/mtrb_ram.sv =====
// Generic single-port RAM with registered read data.
// Standalone; width and depth come from its parameters.
module mtrb_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic                                       re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
	input  logic [WIDTH-1:0]                           wdata,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end else if (re) begin
			rdata <= mem_q[addr];
		end
	end

endmodule

// ===== hw/rtl/mtrb_front.sv =====
// Front end: accepts items, keeps the ring positions and overflow count,
// and classifies each item into a command. Depends on mtrb_pkg and the macros header.
`include "metric_trace_ring_buffer_top_macros.svh"

module mtrb_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  logic                full,
	input  logic                op,
	input  logic [7:0]          metric_kind,
	input  logic [31:0]         process_id,
	input  logic signed [31:0]  device_index,
	input  logic [63:0]         time_ns,
	input  logic [63:0]         metric_value,
	input  logic [63:0]         address_tag,
	output logic                push,
	output mtrb_pkg::cmd_t      cmd
);

	logic [63:0]                 wpos_q;
	logic [63:0]                 rpos_q;
	logic [mtrb_pkg::SLOT_W-1:0] wslot_q;
	logic [mtrb_pkg::SLOT_W-1:0] rslot_q;
	logic [31:0]                 ovf_q;

	logic                        is_write;
	logic                        overflow;
	logic                        empty;
	logic [31:0]                 ovf_nxt;
	logic [mtrb_pkg::SLOT_W-1:0] wslot_nxt;
	logic [mtrb_pkg::SLOT_W-1:0] rslot_nxt;
	logic [63:0]                 lead;

	localparam logic [mtrb_pkg::SLOT_W-1:0] LAST_SLOT =
		mtrb_pkg::SLOT_W'(mtrb_pkg::RING_ENTRIES - 1);

	always_comb begin
		push     = start && !full;
		is_write = (op == mtrb_pkg::OP_WRITE);
		lead     = wpos_q - rpos_q;
		overflow = (lead >= 64'(mtrb_pkg::RING_ENTRIES));
		empty    = (rpos_q >= wpos_q);
		ovf_nxt  = (overflow && (ovf_q != '1)) ? ovf_q + 32'd1 : ovf_q;

		// A position wrapping past 2^64 restarts its slot at zero as well.
		if (wpos_q == '1 || wslot_q == LAST_SLOT) begin
			wslot_nxt = '0;
		end else begin
			wslot_nxt = wslot_q + mtrb_pkg::SLOT_W'(1);
		end
		if (rpos_q == '1 || rslot_q == LAST_SLOT) begin
			rslot_nxt = '0;
		end else begin
			rslot_nxt = rslot_q + mtrb_pkg::SLOT_W'(1);
		end

		cmd.is_write    = is_write;
		cmd.rec.kind    = metric_kind;
		cmd.rec.process = process_id;
		cmd.rec.device  = device_index;
		cmd.rec.tstamp  = time_ns;
		cmd.rec.value   = metric_value;
		cmd.rec.addr    = address_tag;
		if (is_write) begin
			cmd.status    = overflow ? mtrb_pkg::ST_OVERFLOW : mtrb_pkg::ST_WRITTEN;
			cmd.slot      = wslot_q;
			cmd.ovf_total = ovf_nxt;
		end else begin
			cmd.status    = empty ? mtrb_pkg::ST_READ_EMPTY : mtrb_pkg::ST_READ_OK;
			cmd.slot      = rslot_q;
			cmd.ovf_total = ovf_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wpos_q  <= '0;
			rpos_q  <= '0;
			wslot_q <= '0;
			rslot_q <= '0;
			ovf_q   <= '0;
		end else if (push) begin
			if (is_write) begin
				wpos_q  <= wpos_q + 64'd1;
				wslot_q <= wslot_nxt;
				ovf_q   <= ovf_nxt;
			end else if (!empty) begin
				rpos_q  <= rpos_q + 64'd1;
				rslot_q <= rslot_nxt;
			end
		end
	end

	`MTRB_ASSERT_NEXT(a_ovf_monotonic, 1'b1, ovf_q >= $past(ovf_q))
	`MTRB_ASSERT_NEXT(a_read_holds_wpos, push && !is_write, $stable(wpos_q))

endmodule

// ===== hw/rtl/mtrb_cmd_queue.sv =====
// Two-entry command queue between the front end and the back end.
// Depends on mtrb_pkg and the macros header.
`include "metric_trace_ring_buffer_top_macros.svh"

module mtrb_cmd_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  mtrb_pkg::cmd_t push_cmd,
	input  logic           pop,
	output logic           full,
	output logic           head_valid,
	output mtrb_pkg::cmd_t head_cmd
);

	mtrb_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;
	logic           do_pop;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	`MTRB_ASSERT_NOW(a_no_push_when_full, push, !full)

endmodule

// ===== hw/rtl/mtrb_back.sv =====
// Back end: carries out queued commands on the record RAM and drives results.
// Depends on mtrb_pkg, mtrb_ram and the macros header.
`include "metric_trace_ring_buffer_top_macros.svh"

module mtrb_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cmd_valid,
	input  mtrb_pkg::cmd_t     cmd,
	output logic               cmd_pop,
	output logic               done,
	output logic [1:0]         status,
	output logic [7:0]         rd_kind,
	output logic [31:0]        rd_process,
	output logic signed [31:0] rd_device,
	output logic [63:0]        rd_time,
	output logic [63:0]        rd_value,
	output logic [63:0]        rd_address,
	output logic [31:0]        overflow_total
);

	logic                       valid_s1;
	mtrb_pkg::status_t          status_s1;
	logic [31:0]                ovf_s1;
	logic                       ram_we;
	logic                       ram_re;
	logic [mtrb_pkg::REC_W-1:0] ram_rdata;
	mtrb_pkg::rec_t             rd_rec;
	logic                       rd_sel;

	// The back end never stalls, so the queue head is taken every cycle.
	assign cmd_pop = cmd_valid;
	assign ram_we  = cmd_valid && cmd.is_write;
	assign ram_re  = cmd_valid && !cmd.is_write && (cmd.status == mtrb_pkg::ST_READ_OK);

	mtrb_ram #(
		.WIDTH(mtrb_pkg::REC_W),
		.DEPTH(mtrb_pkg::RING_ENTRIES)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (ram_re),
		.addr (cmd.slot),
		.wdata(cmd.rec),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= cmd_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_valid) begin
			status_s1 <= cmd.status;
			ovf_s1    <= cmd.ovf_total;
		end
	end

	assign rd_rec = mtrb_pkg::rec_t'(ram_rdata);
	assign rd_sel = (status_s1 == mtrb_pkg::ST_READ_OK);

	assign done           = valid_s1;
	assign status         = status_s1;
	assign overflow_total = ovf_s1;
	assign rd_kind        = rd_sel ? rd_rec.kind    : '0;
	assign rd_process     = rd_sel ? rd_rec.process : '0;
	assign rd_device      = rd_sel ? rd_rec.device  : '0;
	assign rd_time        = rd_sel ? rd_rec.tstamp  : '0;
	assign rd_value       = rd_sel ? rd_rec.value   : '0;
	assign rd_address     = rd_sel ? rd_rec.addr    : '0;

	`MTRB_ASSERT_NEXT(a_done_follows_pop, cmd_pop, done)

endmodule
